// ----- rtl/kpd_pkg.sv -----
// Types, constants and lookup functions for the keypad scanner with debounce and display.
package kpd_pkg;

  localparam int unsigned DISPLAY_DIGITS = 4;
  localparam int unsigned DIGIT_W        = $clog2(DISPLAY_DIGITS);
  localparam int unsigned ROWS           = 4;
  localparam int unsigned COLS           = 4;
  localparam int unsigned KEY_W          = 5;
  localparam int unsigned SEG_W          = 8;
  localparam int unsigned TIME_W         = 32;
  localparam int unsigned DEBOUNCE_W     = 16;

  localparam logic [KEY_W-1:0]      KEY_NONE       = 5'd16;
  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd40;

  typedef struct packed {
    logic [1:0]        scan_row;
    logic [COLS-1:0]   column_lines;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic               key_accepted;
    logic [KEY_W-1:0]   key_code;
    logic [DIGIT_W-1:0] digit_select;
    logic [SEG_W-1:0]   segment_pattern;
  } out_item_t;

  typedef logic [KEY_W-1:0] key_row_t [COLS];

  // Keys by row, columns in priority order
  localparam key_row_t KEY_MAP [ROWS] = '{
    '{5'd1,  5'd2, 5'd3,  5'd10},
    '{5'd4,  5'd5, 5'd6,  5'd11},
    '{5'd7,  5'd8, 5'd9,  5'd12},
    '{5'd14, 5'd0, 5'd15, 5'd13}
  };

  localparam logic [SEG_W-1:0] SEG_MAP [16] = '{
    8'hFC, 8'h60, 8'hDA, 8'hF2, 8'h66, 8'hB6, 8'hBE, 8'hE0,
    8'hFE, 8'hE6, 8'hEE, 8'h3E, 8'h9C, 8'h7A, 8'h9E, 8'h8E
  };

  // First low column wins; none low gives KEY_NONE
  function automatic logic [KEY_W-1:0] decode_key(input logic [1:0] row,
                                                  input logic [COLS-1:0] cols);
    logic [KEY_W-1:0] key;
    key = KEY_NONE;
    for (int c = COLS - 1; c >= 0; c--) begin
      if (!cols[c]) begin
        key = KEY_MAP[row][c];
      end
    end
    return key;
  endfunction

  function automatic logic [SEG_W-1:0] seg_of(input logic [KEY_W-1:0] key);
    return SEG_MAP[key[3:0]];
  endfunction

endpackage

// ----- rtl/keypad_scan_debounce_display.sv -----
// Keypad row-scan decoder with shared debounce timer and four-digit segment store.
//
//  Channel | Direction | Handshake            | Payload
//  in      | input     | in_valid_i/ready_o   | kpd_pkg::in_item_t   (one row scan)
//  out     | output    | out_valid_o/ready_i  | kpd_pkg::out_item_t  (one result per scan)
//  cfg     | input     | cfg_valid_i/ready_o  | cfg_debounce_ms_i    (debounce time, ms)
//
// One scan per cycle sustained while the output is not stalled; a scan's transaction loads the
// input register, then decode/compare/shift logic feeds the result register, where the result
// is presented and can be taken.
// Reset clears keys to none, change time to zero, the digit store to blank, debounce to 40.
// An output stall holds the result register; the input register then fills and ready drops.
// The configuration port is always ready.
module keypad_scan_debounce_display (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  kpd_pkg::in_item_t   in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output kpd_pkg::out_item_t  out_item_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [15:0]         cfg_debounce_ms_i
);
  import kpd_pkg::*;

  logic                  s1_valid_q;
  in_item_t              in_q;
  logic                  out_valid_q;
  out_item_t             out_q;
  logic [DEBOUNCE_W-1:0] debounce_q;
  logic [KEY_W-1:0]      last_seen_q [ROWS];
  logic [KEY_W-1:0]      stable_q [ROWS];
  logic [TIME_W-1:0]     last_change_q;
  logic [SEG_W-1:0]      store_q [DISPLAY_DIGITS];
  logic [SEG_W-1:0]      store_d [DISPLAY_DIGITS];

  logic              out_free;
  logic              adv;
  logic [KEY_W-1:0]  key;
  logic              changed;
  logic [TIME_W-1:0] elapsed;
  logic              timed_out;
  logic              take;
  logic              push;

  assign out_free    = !out_valid_q || out_ready_i;
  assign adv         = s1_valid_q && out_free;
  assign in_ready_o  = !s1_valid_q || out_free;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_comb begin
    key       = decode_key(in_q.scan_row, in_q.column_lines);
    changed   = key != last_seen_q[in_q.scan_row];
    elapsed   = in_q.now_ms - last_change_q;
    // a change in this scan restarts the timer, so the scan cannot time out then
    timed_out = !changed && ((elapsed[TIME_W-1:DEBOUNCE_W] != '0) ||
                             (elapsed[DEBOUNCE_W-1:0] > debounce_q));
    take      = timed_out && (key != stable_q[in_q.scan_row]);
    push      = take && (key != KEY_NONE);
    for (int i = 0; i < DISPLAY_DIGITS; i++) begin
      store_d[i] = store_q[i];
    end
    if (push) begin
      for (int i = DISPLAY_DIGITS - 1; i > 0; i--) begin
        store_d[i] = store_q[i-1];
      end
      store_d[0] = seg_of(key);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
    if (adv) begin
      out_q.key_accepted    <= push;
      out_q.key_code        <= key;
      out_q.digit_select    <= in_q.scan_row;
      out_q.segment_pattern <= store_d[in_q.scan_row];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_q    <= DEBOUNCE_RESET;
      last_change_q <= '0;
      for (int i = 0; i < ROWS; i++) begin
        last_seen_q[i] <= KEY_NONE;
        stable_q[i]    <= KEY_NONE;
      end
      for (int i = 0; i < DISPLAY_DIGITS; i++) begin
        store_q[i] <= '0;
      end
    end else begin
      if (cfg_valid_i) begin
        debounce_q <= cfg_debounce_ms_i;
      end
      if (adv) begin
        last_seen_q[in_q.scan_row] <= key;
        if (changed) begin
          last_change_q <= in_q.now_ms;
        end
        if (take) begin
          stable_q[in_q.scan_row] <= key;
        end
        for (int i = 0; i < DISPLAY_DIGITS; i++) begin
          store_q[i] <= store_d[i];
        end
      end
    end
  end

endmodule

// ----- rtl/kpd_checker.sv -----
// Port-level checks for the keypad scanner, bound to the top level.
module kpd_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input kpd_pkg::out_item_t out_item_o
);
  import kpd_pkg::*;

  // input side only stalls behind a full result register
  a_ready_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

  a_accept_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.key_accepted) |-> (out_item_o.key_code != KEY_NONE))
    else $error("key none reported as accepted");

  // an accepted key lands in digit 0, so that digit cannot be blank
  a_accept_seg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.key_accepted && (out_item_o.digit_select == '0))
      |-> (out_item_o.segment_pattern != '0))
    else $error("digit 0 blank after accepted key");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("stalled output transaction changed");

endmodule

bind keypad_scan_debounce_display kpd_checker u_kpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

// ----- tb/sv/keypad_scan_debounce_display_tb.sv -----
// Self-checking testbench for the keypad scanner with debounce and digit display.
`timescale 1ns / 1ps

module keypad_scan_debounce_display_tb;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned HOLD_CYCLES  = 300;

  // Key per row and column, entry (row * 4 + col); first entry in the lowest bits
  localparam logic [16*5-1:0] KEYPAD_LAYOUT = {
    5'd13, 5'd15, 5'd0, 5'd14,
    5'd12, 5'd9,  5'd8, 5'd7,
    5'd11, 5'd6,  5'd5, 5'd4,
    5'd10, 5'd3,  5'd2, 5'd1
  };
  // Segment patterns by key code 0..15, code 0 in the lowest byte
  localparam logic [16*8-1:0] SEGMENT_CODES = 128'h8E9E7A9C3EEEE6FEE0BEB666F2DA60FC;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  kpd_pkg::in_item_t   in_item_i;
  logic                out_valid_o;
  logic                out_ready_i;
  kpd_pkg::out_item_t  out_item_o;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [15:0]         cfg_debounce_ms_i;

  // Predictor state
  logic [4:0]  seen_key [4];
  logic [4:0]  settled_key [4];
  logic [31:0] change_ms;
  logic [7:0]  shown_digits [4];
  logic [15:0] debounce_ms;

  kpd_pkg::out_item_t expected_readouts [$];

  int          mismatch_count = 0;
  int unsigned cycle_count = 0;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  logic        hold_request = 1'b0;
  int          hold_left = 0;
  logic [31:0] scan_ms = 32'd0;

  keypad_scan_debounce_display u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .in_item_i         (in_item_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .out_item_o        (out_item_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_debounce_ms_i (cfg_debounce_ms_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic kpd_pkg::out_item_t predict_scan(input kpd_pkg::in_item_t scan);
    kpd_pkg::out_item_t res;
    logic [4:0]  key;
    logic [1:0]  row;
    logic [31:0] elapsed;
    row = scan.scan_row;
    key = kpd_pkg::KEY_NONE;
    // lowest low column has priority, so scan from the top down
    for (int c = 3; c >= 0; c--) begin
      if (!scan.column_lines[c]) begin
        key = KEYPAD_LAYOUT[(row * 4 + c) * 5 +: 5];
      end
    end
    if (key != seen_key[row]) begin
      change_ms = scan.now_ms;
    end
    elapsed = scan.now_ms - change_ms;
    res.key_accepted = 1'b0;
    if (elapsed > {16'd0, debounce_ms} && key != settled_key[row]) begin
      settled_key[row] = key;
      if (key != kpd_pkg::KEY_NONE) begin
        for (int i = 3; i > 0; i--) begin
          shown_digits[i] = shown_digits[i-1];
        end
        shown_digits[0] = SEGMENT_CODES[key[3:0] * 8 +: 8];
        res.key_accepted = 1'b1;
      end
    end
    seen_key[row] = key;
    res.key_code = key;
    res.digit_select = row;
    res.segment_pattern = shown_digits[row];
    return res;
  endfunction

  // Result check first, then the new scan, so a result is never matched to a scan taken at the same edge
  always @(posedge clk_i) begin : monitor_b
    kpd_pkg::out_item_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_readouts.size() == 0) begin
          $error("result transaction with no scan pending");
          mismatch_count++;
        end else begin
          want = expected_readouts.pop_front();
          if (out_item_o.key_accepted !== want.key_accepted) begin
            $error("key_accepted: expected %0d, got %0d", want.key_accepted,
                   out_item_o.key_accepted);
            mismatch_count++;
          end
          if (out_item_o.key_code !== want.key_code) begin
            $error("key_code: expected %0d, got %0d", want.key_code, out_item_o.key_code);
            mismatch_count++;
          end
          if (out_item_o.digit_select !== want.digit_select) begin
            $error("digit_select: expected %0d, got %0d", want.digit_select,
                   out_item_o.digit_select);
            mismatch_count++;
          end
          if (out_item_o.segment_pattern !== want.segment_pattern) begin
            $error("segment_pattern: expected %h, got %h", want.segment_pattern,
                   out_item_o.segment_pattern);
            mismatch_count++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        expected_readouts.push_back(predict_scan(in_item_i));
      end
      if (cfg_valid_i && cfg_ready_o) begin
        debounce_ms = cfg_debounce_ms_i;
      end
    end
  end

  // Receiver: long hold-off on request, otherwise random stalls
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i = 1'b0;
    end else begin
      out_ready_i = ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic send_scan(input logic [1:0] row, input logic [3:0] cols,
                           input logic [31:0] stamp);
    kpd_pkg::in_item_t scan;
    scan.scan_row = row;
    scan.column_lines = cols;
    scan.now_ms = stamp;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_item_i = scan;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (expected_readouts.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_debounce(input logic [15:0] value);
    wait_drained();
    cfg_valid_i = 1'b1;
    cfg_debounce_ms_i = value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Full row sweeps with one key held then released; bursts of noise in between
  task automatic random_presses(input int n_items, input int unsigned step_max);
    int         sent;
    int         row_hit;
    int         col_hit;
    int         press_sweeps;
    int         all_sweeps;
    logic [3:0] below;
    logic [3:0] cols;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 75) begin
        row_hit = $urandom_range(3);
        col_hit = $urandom_range(3);
        press_sweeps = $urandom_range(1, 8);
        all_sweeps = press_sweeps + $urandom_range(1, 5);
        below = (4'b1 << col_hit) - 4'b1;
        for (int s = 0; s < all_sweeps; s++) begin
          for (int r = 0; r < 4; r++) begin
            if (s < press_sweeps && r == row_hit) begin
              cols = (4'($urandom_range(15)) | below) & ~(4'b1 << col_hit);
            end else begin
              cols = 4'hF;
            end
            if ($urandom_range(99) < 8) begin
              cols = 4'($urandom_range(15));   // contact bounce
            end
            scan_ms = scan_ms + $urandom_range(0, step_max);
            send_scan(2'(r), cols, scan_ms);
            sent++;
          end
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(99) < 30) begin
            scan_ms = $urandom;   // jump anywhere, wrap and step back included
          end else begin
            scan_ms = scan_ms + $urandom_range(0, step_max);
          end
          send_scan(2'($urandom_range(3)), 4'($urandom_range(15)), scan_ms);
          sent++;
        end
      end
    end
  endtask

  task automatic test_reset_state();
    for (int r = 0; r < 4; r++) begin
      send_scan(2'(r), 4'hF, 32'd0);
    end
  endtask

  // Reset debounce of 40: elapsed 40 is not enough, 41 is
  task automatic test_column_priority();
    send_scan(2'd3, 4'b0000, 32'd1);
    send_scan(2'd3, 4'b0000, 32'd41);
    send_scan(2'd3, 4'b0000, 32'd42);
    send_scan(2'd0, 4'b1111, 32'd42);
  endtask

  task automatic test_time_wrap();
    write_debounce(16'd0);
    send_scan(2'd0, 4'b0111, 32'hFFFF_FFFF);
    send_scan(2'd0, 4'b0111, 32'd0);
    send_scan(2'd0, 4'b1111, 32'd5);
    send_scan(2'd0, 4'b1111, 32'd6);
    send_scan(2'd1, 4'b1101, 32'd100);
    send_scan(2'd1, 4'b1101, 32'd50);
    send_scan(2'd2, 4'b1110, 32'd50);
    send_scan(2'd2, 4'b1110, 32'd50);
    send_scan(2'd2, 4'b1110, 32'd51);
  endtask

  task automatic test_max_debounce();
    write_debounce(16'hFFFF);
    send_scan(2'd3, 4'b1011, 32'd1000);
    send_scan(2'd3, 4'b1011, 32'd1000 + 32'd65535);
    send_scan(2'd3, 4'b1011, 32'd1000 + 32'd65536);
    send_scan(2'd0, 4'b1111, 32'd1000 + 32'd65537);
  endtask

  // Receiver held off so the block fills, then a pause until all results are in
  task automatic test_backpressure();
    write_debounce(16'd3);
    send_idle_pct = 0;
    stall_pct = 0;
    hold_request = 1'b1;
    random_presses(60, 2);
    wait_drained();
    random_presses(20, 2);
  endtask

  task automatic test_random_phases();
    logic [15:0] setting;
    int unsigned step_max;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin setting = 16'd0;     step_max = 3;     send_idle_pct = 0;  stall_pct = 0;  end
        1: begin setting = 16'd9;     step_max = 5;     send_idle_pct = 62; stall_pct = 0;  end
        2: begin setting = 16'd40;    step_max = 12;    send_idle_pct = 0;  stall_pct = 62; end
        default: begin
          setting = 16'hFFFF; step_max = 24000; send_idle_pct = 17; stall_pct = 17;
        end
      endcase
      write_debounce(setting);
      random_presses(180, step_max);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    out_ready_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_debounce_ms_i = 16'd0;
    for (int r = 0; r < 4; r++) begin
      seen_key[r] = kpd_pkg::KEY_NONE;
      settled_key[r] = kpd_pkg::KEY_NONE;
      shown_digits[r] = 8'h00;
    end
    change_ms = 32'd0;
    debounce_ms = kpd_pkg::DEBOUNCE_RESET;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_state();
    test_column_priority();
    test_time_wrap();
    test_max_debounce();
    test_backpressure();
    test_random_phases();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
